### design/ogi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid inflation package
// Shared types and constants for the occupancy grid inflation block.
// ----------------------------------------------------------------------------
package ogi_pkg;

   typedef logic [1:0]  cell_code_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [10:0] csr_data_type;
   typedef logic [9:0]  coord_type;
   typedef logic [7:0]  level_type;

   localparam cell_code_type CODE_FREE     = 2'd0;
   localparam cell_code_type CODE_OCCUPIED = 2'd1;
   localparam cell_code_type CODE_UNKNOWN  = 2'd2;

   localparam csr_index_type CSR_GRID_WIDTH     = 2'd0;
   localparam csr_index_type CSR_GRID_HEIGHT    = 2'd1;
   localparam csr_index_type CSR_INFLATE_RADIUS = 2'd2;

   localparam level_type LEVEL_BLOCKED = 8'd0;
   localparam level_type LEVEL_FREE    = 8'd255;
   localparam level_type LEVEL_UNKNOWN = 8'd128;

   localparam int RESET_GRID_WIDTH  = 1024;
   localparam int RESET_GRID_HEIGHT = 1024;
   localparam int RESET_RADIUS      = 1;

endpackage

### design/occupancy_grid_inflation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid inflation
// Square-window dilation of obstacles over a raster stream of grid cells.
// ----------------------------------------------------------------------------
// Cells enter in raster order on the req_ channel, one beat per cell, and each
// interior cell leaves as one beat on the rsp_ channel with its row, column,
// inflated flag, gray level and an end-of-frame mark. Border cells within the
// radius of an edge produce no beat.
// The csr_ port sets grid width, grid height and radius; any write to one of
// them restarts the frame at row zero, column zero. Write only while idle.
// A cell is taken every cycle while the pipeline is not stalled. Each result
// passes through the stage-one, stage-two and result registers to rsp_valid;
// the rate is set by the column store, a single memory with one read and one
// write per cycle holding the last 2*MAX_RADIUS cell codes of every column.
// When the receiver stalls, the whole pipeline holds and req_ready drops in
// the same cycle; the pending result stays in the output register.
// Reset clears the counters and pipeline valid bits and restores the default
// configuration; the column store needs no clearing because a window never
// reaches a place not yet written in the current frame.
// ----------------------------------------------------------------------------
module occupancy_grid_inflation #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ogi_pkg::cell_code_type req_cell_code,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ogi_pkg::coord_type     rsp_out_row,
   output ogi_pkg::coord_type     rsp_out_col,
   output logic                   rsp_inflated,
   output ogi_pkg::level_type     rsp_pixel_level,
   output logic                   rsp_frame_last,
   input  logic                   csr_we,
   input  ogi_pkg::csr_index_type csr_addr,
   input  ogi_pkg::csr_data_type  csr_wdata
);
   import ogi_pkg::*;

   localparam int CB   = $clog2(MAX_WIDTH);
   localparam int RB   = $clog2(MAX_HEIGHT);
   localparam int RDB  = $clog2(MAX_RADIUS + 1);
   localparam int WIN  = 2 * MAX_RADIUS + 1;
   localparam int WIB  = $clog2(WIN);
   localparam int VB   = 4 * MAX_RADIUS;
   localparam int CMPW = ((RB > CB) ? RB : CB) + RDB + 1;
   localparam int RST_W = (RESET_GRID_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_GRID_WIDTH;
   localparam int RST_H = (RESET_GRID_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_GRID_HEIGHT;
   localparam int RST_R = (RESET_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RESET_RADIUS;

   logic [CB-1:0]  last_col_ff;
   logic [RB-1:0]  last_row_ff;
   logic [RDB-1:0] radius_ff;
   logic [CB-1:0]  last_col_in;
   logic [RB-1:0]  last_row_in;
   logic [RDB-1:0] radius_in;
   logic           csr_hit;

   logic [CB-1:0]  col_ff;
   logic [RB-1:0]  row_ff;
   logic [CB-1:0]  col_in;
   logic [RB-1:0]  row_in;

   logic adv;
   logic accept;
   logic emit_now;

   logic [VB-1:0] col_mem [MAX_WIDTH];
   logic [VB-1:0] rd_ff;
   logic [VB-1:0] wb_vec_ff;

   logic          s1_valid_ff;
   logic          s1_fwd_ff;
   cell_code_type s1_code_ff;
   logic [CB-1:0] s1_col_ff;
   coord_type     s1_orow_ff;
   coord_type     s1_ocol_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;

   logic          s2_valid_ff;
   coord_type     s2_orow_ff;
   coord_type     s2_ocol_ff;
   logic          s2_emit_ff;
   logic          s2_last_ff;

   logic [VB+1:0]  col_vec;
   logic [VB-1:0]  old_vec;
   cell_code_type  col_codes [WIN];
   logic [WIN-1:0] occ_col;

   logic [WIN-1:0] win_occ_ff [WIN];
   cell_code_type  win_ctr_ff [WIN];

   logic          hit;
   cell_code_type center;
   level_type     level;

   logic          rsp_valid_ff;
   coord_type     rsp_row_ff;
   coord_type     rsp_col_ff;
   logic          rsp_infl_ff;
   level_type     rsp_level_ff;
   logic          rsp_last_ff;

   // Configuration values are clamped when written.
   always_comb begin
      csr_hit     = 1'b0;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      radius_in   = radius_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_GRID_WIDTH: begin
               csr_hit = 1'b1;
               if (csr_wdata == '0) begin
                  last_col_in = '0;
               end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  last_col_in = CB'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = CB'(csr_wdata - 11'd1);
               end
            end
            CSR_GRID_HEIGHT: begin
               csr_hit = 1'b1;
               if (csr_wdata == '0) begin
                  last_row_in = '0;
               end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
                  last_row_in = RB'(MAX_HEIGHT - 1);
               end else begin
                  last_row_in = RB'(csr_wdata - 11'd1);
               end
            end
            CSR_INFLATE_RADIUS: begin
               csr_hit = 1'b1;
               if (32'(csr_wdata[3:0]) > 32'(MAX_RADIUS)) begin
                  radius_in = RDB'(MAX_RADIUS);
               end else begin
                  radius_in = RDB'(csr_wdata[3:0]);
               end
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= CB'(RST_W - 1);
         last_row_ff <= RB'(RST_H - 1);
         radius_ff   <= RDB'(RST_R);
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         radius_ff   <= radius_in;
      end
   end

   assign adv      = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept   = req_valid && adv;

   always_comb begin
      if (col_ff == last_col_ff) begin
         col_in = '0;
         row_in = (row_ff == last_row_ff) ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_hit) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign emit_now = (CMPW'(row_ff) >= CMPW'({radius_ff, 1'b0}))
                  && (CMPW'(col_ff) >= CMPW'({radius_ff, 1'b0}));

   // Stage one: column store read and input capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s1_fwd_ff   <= s1_valid_ff && (s1_col_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff      <= col_mem[col_ff];
         wb_vec_ff  <= col_vec[VB-1:0];
         s1_code_ff <= req_cell_code;
         s1_col_ff  <= col_ff;
         s1_orow_ff <= coord_type'(row_ff - RB'(radius_ff));
         s1_ocol_ff <= coord_type'(col_ff - CB'(radius_ff));
         s1_emit_ff <= emit_now;
         s1_last_ff <= (row_ff == last_row_ff) && (col_ff == last_col_ff);
      end
      if (adv && s1_valid_ff) begin
         col_mem[s1_col_ff] <= col_vec[VB-1:0];
      end
   end

   assign old_vec = s1_fwd_ff ? wb_vec_ff : rd_ff;
   assign col_vec = {old_vec, s1_code_ff};

   always_comb begin
      for (int k = 0; k < WIN; k++) begin
         col_codes[k] = col_vec[2*k +: 2];
         occ_col[k]   = (col_vec[2*k +: 2] == CODE_OCCUPIED)
                     && (k <= 2 * int'(radius_ff));
      end
   end

   // Stage two: window shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_orow_ff <= s1_orow_ff;
         s2_ocol_ff <= s1_ocol_ff;
         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (adv && s1_valid_ff) begin
         win_occ_ff[0] <= occ_col;
         win_ctr_ff[0] <= col_codes[WIB'(radius_ff)];
         for (int j = 1; j < WIN; j++) begin
            win_occ_ff[j] <= win_occ_ff[j-1];
            win_ctr_ff[j] <= win_ctr_ff[j-1];
         end
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int j = 0; j < WIN; j++) begin
         for (int k = 0; k < WIN; k++) begin
            if ((j <= 2 * int'(radius_ff)) && win_occ_ff[j][k]
                && !((j == int'(radius_ff)) && (k == int'(radius_ff)))) begin
               hit = 1'b1;
            end
         end
      end
      center = win_ctr_ff[WIB'(radius_ff)];
      if (hit || (center == CODE_OCCUPIED)) begin
         level = LEVEL_BLOCKED;
      end else if (center == CODE_FREE) begin
         level = LEVEL_FREE;
      end else begin
         level = LEVEL_UNKNOWN;
      end
   end

   // Stage three: result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff && s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_row_ff   <= s2_orow_ff;
         rsp_col_ff   <= s2_ocol_ff;
         rsp_infl_ff  <= hit;
         rsp_level_ff <= level;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_inflated    = rsp_infl_ff;
   assign rsp_pixel_level = rsp_level_ff;
   assign rsp_frame_last  = rsp_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (col_ff <= last_col_ff) && (row_ff <= last_row_ff))
      else $error("Raster position is outside the configured grid.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_row_ff)
         && $stable(rsp_col_ff) && $stable(rsp_level_ff))
      else $error("Result beat changed while the receiver stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_infl_ff |-> rsp_level_ff == LEVEL_BLOCKED)
      else $error("Inflated cell reported with a nonzero gray level.");

   assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (col_ff == '0) && (row_ff == '0))
      else $error("Register write did not restart the frame.");
`endif

endmodule
